### src/ftwr_pkg.sv
`timescale 1ns / 1ps

package ftwr_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned NUM_WORDS = 4;
   localparam int unsigned POS_W = 4;

   localparam logic [POS_W-1:0] POS_HUNT = 4'd0;
   localparam logic [POS_W-1:0] POS_FIRST = 4'd1;
   localparam logic [POS_W-1:0] POS_LAST_DATA = 4'd8;
   localparam logic [POS_W-1:0] POS_END = 4'd9;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAF;
   localparam logic [BYTE_W-1:0] END_RESET = 8'hED;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic CSR_IDX_HEADER = 1'b0;
   localparam logic CSR_IDX_END = 1'b1;

   localparam int unsigned RSP_DATA_W = 72;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_END = 2'd1,
      STATUS_BAD_SUM = 2'd2
   } status_type;

   typedef struct packed {
      logic                    done;
      status_type              status;
      logic signed [WORD_W-1:0] value_first;
      logic signed [WORD_W-1:0] value_second;
      logic signed [WORD_W-1:0] value_third;
      logic signed [WORD_W-1:0] sent_checksum;
   } frame_result_type;

endpackage

### src/ftwr_parser.sv
`timescale 1ns / 1ps

module ftwr_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  logic [ftwr_pkg::BYTE_W-1:0]       rx_byte,
   input  logic [ftwr_pkg::BYTE_W-1:0]       header_code,
   input  logic [ftwr_pkg::BYTE_W-1:0]       end_code,
   output ftwr_pkg::frame_result_type        result
);

   logic [ftwr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [ftwr_pkg::BYTE_W-1:0] high_ff, high_in;
   logic [ftwr_pkg::WORD_W-1:0] sum_ff, sum_in;
   logic [ftwr_pkg::WORD_W-1:0] words_ff [ftwr_pkg::NUM_WORDS];
   logic [ftwr_pkg::WORD_W-1:0] word_in;
   logic [ftwr_pkg::POS_W-1:0]  pos_m1;
   logic [1:0]                  word_idx;
   logic                        in_data;
   logic                        word_wr;

   assign in_data  = (pos_ff >= ftwr_pkg::POS_FIRST) && (pos_ff <= ftwr_pkg::POS_LAST_DATA);
   assign pos_m1   = pos_ff - ftwr_pkg::POS_FIRST;
   assign word_idx = pos_m1[2:1];
   // even positions carry the low byte and complete a word
   assign word_wr  = step && in_data && !pos_ff[0];
   assign word_in  = {high_ff, rx_byte};

   always_comb begin
      pos_in  = pos_ff;
      high_in = high_ff;
      sum_in  = sum_ff;
      if (step) begin
         if (in_data) begin
            pos_in = pos_ff + 4'd1;
            if (pos_ff[0]) begin
               high_in = rx_byte;
            end else if (word_idx != 2'd3) begin
               sum_in = sum_ff + word_in;
            end
         end else if (pos_ff == ftwr_pkg::POS_END) begin
            pos_in = ftwr_pkg::POS_HUNT;
         end else if (rx_byte == header_code) begin
            pos_in  = ftwr_pkg::POS_FIRST;
            sum_in  = '0;
            high_in = '0;
         end else begin
            pos_in = ftwr_pkg::POS_HUNT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= ftwr_pkg::POS_HUNT;
         high_ff <= '0;
         sum_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         high_ff <= high_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (word_wr) begin
         words_ff[word_idx] <= word_in;
      end
   end

   always_comb begin
      result.done          = (pos_ff == ftwr_pkg::POS_END);
      result.value_first   = words_ff[0];
      result.value_second  = words_ff[1];
      result.value_third   = words_ff[2];
      result.sent_checksum = words_ff[3];
      if (rx_byte != end_code) begin
         result.status = ftwr_pkg::STATUS_BAD_END;
      end else if (words_ff[3] != sum_ff) begin
         result.status = ftwr_pkg::STATUS_BAD_SUM;
      end else begin
         result.status = ftwr_pkg::STATUS_OK;
      end
   end

endmodule

### src/framed_triple_word_receiver.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload                                        Handshake
// req      in   tdata[7:0] rx_byte                             tvalid/tready
// rsp      out  tdata[71:0] status, 3 values, checksum         tvalid/tready
// csr      in   APB, 0x0 header_code, 0x4 end_code             psel/penable, pready=1
//
// One byte per cycle when not held up: each beat passes through the input
// register, then the parser updates its position counter and single 16-bit adder.
// A frame result is captured in the output register as its end-position byte
// leaves the input register. Reset (synchronous) returns to hunting with default
// codes. A stalled rsp holds up the input register only at an end-position byte.

module framed_triple_word_receiver (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,   // [7:0] rx_byte

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [1:0] frame_status, [17:2] value_first, [33:18] value_second,
   // [49:34] value_third, [65:50] sent_checksum, [71:66] zero
   output logic [ftwr_pkg::RSP_DATA_W-1:0]       rsp_tdata,

   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ftwr_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [ftwr_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [ftwr_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);

   logic                          in_valid_ff, in_valid_in;
   logic [ftwr_pkg::BYTE_W-1:0]   in_byte_ff;
   logic                          out_valid_ff, out_valid_in;
   ftwr_pkg::frame_result_type    out_ff;
   ftwr_pkg::frame_result_type    result;
   logic [ftwr_pkg::BYTE_W-1:0]   header_ff, end_ff;
   logic                          advance;
   logic                          out_free;
   logic                          csr_wr;
   logic                          csr_idx;

   // ---- configuration ----
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= ftwr_pkg::HEADER_RESET;
         end_ff    <= ftwr_pkg::END_RESET;
      end else if (csr_wr) begin
         if (csr_idx == ftwr_pkg::CSR_IDX_HEADER) begin
            header_ff <= csr_pwdata[ftwr_pkg::BYTE_W-1:0];
         end else begin
            end_ff <= csr_pwdata[ftwr_pkg::BYTE_W-1:0];
         end
      end
   end

   always_comb begin
      if (csr_idx == ftwr_pkg::CSR_IDX_HEADER) begin
         csr_prdata = {{(ftwr_pkg::CSR_DATA_W-ftwr_pkg::BYTE_W){1'b0}}, header_ff};
      end else begin
         csr_prdata = {{(ftwr_pkg::CSR_DATA_W-ftwr_pkg::BYTE_W){1'b0}}, end_ff};
      end
   end

   // ---- input register ----
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!result.done || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   ftwr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .rx_byte     (in_byte_ff),
      .header_code (header_ff),
      .end_code    (end_ff),
      .result      (result)
   );

   // ---- output register ----
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (advance && result.done) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.done) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_ff.sent_checksum, out_ff.value_third,
                        out_ff.value_second, out_ff.value_first, out_ff.status};

endmodule
